/* rtl/stmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmc_pkg: shared types and constants of the sorted table membership counter
// Table geometry, request codes and the handshake structs between the
// search sequencer and the top level.
// ----------------------------------------------------------------------------
package stmc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int HIT_BITS    = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // Count must hold the full depth itself
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [HIT_BITS-1:0]   hit_t;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam hit_t HIT_MAX = {HIT_BITS{1'b1}};

  typedef struct packed {
    logic   start;
    value_t key;
    cnt_t   count;
  } search_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } search_rsp_t;

endpackage

/* rtl/sorted_table_membership_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_membership_counter: binary-search membership test with hit count
//
// Input channel (in_valid / in_stall): each word carries a request code and a
// signed value. Clear empties the table and zeroes the hit count; load appends
// the value (dropped once the table holds 1024 entries); query searches the
// loaded entries. The host must load entries in ascending signed order.
// Result channel (out_valid / out_stall): one word per query, giving found
// and the saturating count of matching queries since the last clear.
// Clear, load and the unused code give no result word.
// Clear and load do not stall the input. A query makes P probes (none on an
// empty table, at most 11 for 1024 entries), one table read each through the
// single read port of the table RAM; its result word is registered after the
// probes, the hand-over of the search result and the report state.
// in_stall is high while the query searches and reports, holding the input.
// A result word sits in the output register while out_stall holds it; a later
// query's result then waits in the report state with the input stalled.
// Reset (rst_n low, synchronous) empties the table and clears the count.
// ----------------------------------------------------------------------------
module sorted_table_membership_counter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic signed [stmc_pkg::VALUE_BITS-1:0] in_item_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic [stmc_pkg::HIT_BITS-1:0] out_match_total
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_REPORT
  } state_t;

  state_t                 state_r, state_nxt;
  stmc_pkg::cnt_t         entry_count_r, entry_count_nxt;
  stmc_pkg::hit_t         hit_count_r, hit_count_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  stmc_pkg::hit_t         out_total_r, out_total_nxt;

  logic                   in_accept;
  stmc_pkg::req_t         req_code;
  logic                   out_free;
  logic                   wr_en;
  logic                   rd_en;
  stmc_pkg::addr_t        rd_addr;
  stmc_pkg::value_t       rd_data;
  stmc_pkg::search_req_t  srch_req;
  stmc_pkg::search_rsp_t  srch_rsp;

  assign in_stall  = (state_r != T_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign req_code  = stmc_pkg::req_t'(in_req_type);
  // Output register can take a new word when empty or draining this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // Append on load while there is room; drop otherwise
  assign wr_en = in_accept && (req_code == stmc_pkg::REQ_LOAD) &&
                 (entry_count_r < stmc_pkg::cnt_t'(stmc_pkg::TABLE_DEPTH));

  assign srch_req.start = in_accept && (req_code == stmc_pkg::REQ_QUERY);
  assign srch_req.key   = in_item_value;
  assign srch_req.count = entry_count_r;

  stmc_table_ram #(
    .DEPTH  (stmc_pkg::TABLE_DEPTH),
    .WIDTH  (stmc_pkg::VALUE_BITS),
    .ADDR_W (stmc_pkg::ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count_r[stmc_pkg::ADDR_W-1:0]),
    .wr_data (in_item_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stmc_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (srch_req),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rsp     (srch_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    hit_count_nxt   = hit_count_r;
    found_nxt       = found_r;
    out_found_nxt   = out_found_r;
    out_total_nxt   = out_total_r;
    // Drop the output word once the receiver takes it
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      T_IDLE: begin
        if (in_accept) begin
          unique case (req_code)
            stmc_pkg::REQ_CLEAR: begin
              entry_count_nxt = '0;
              hit_count_nxt   = '0;
            end
            stmc_pkg::REQ_LOAD: begin
              if (wr_en) begin
                entry_count_nxt = entry_count_r + stmc_pkg::cnt_t'(1);
              end
            end
            stmc_pkg::REQ_QUERY: begin
              state_nxt = T_SEARCH;
            end
            default: ;
          endcase
        end
      end
      T_SEARCH: begin
        if (srch_rsp.done) begin
          found_nxt = srch_rsp.hit;
          state_nxt = T_REPORT;
        end
      end
      T_REPORT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          if (found_r && (hit_count_r != stmc_pkg::HIT_MAX)) begin
            hit_count_nxt = hit_count_r + stmc_pkg::hit_t'(1);
          end
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_total_nxt = (found_r && (hit_count_r != stmc_pkg::HIT_MAX)) ?
                          hit_count_r + stmc_pkg::hit_t'(1) : hit_count_r;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      entry_count_r <= '0;
      hit_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      hit_count_r   <= hit_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_total = out_total_r;

`ifndef ASSERT_OFF
  // The search only finishes while a query is outstanding
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (state_r == T_SEARCH))
    else $error("search finished outside of a query");

  // Table fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= stmc_pkg::cnt_t'(stmc_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Table reads are issued only by a query in flight or one starting now
  a_read_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ((state_r == T_SEARCH) || srch_req.start))
    else $error("table read outside of a query");

  // The hit count moves only in the report state or on clear
  a_hit_steady: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == T_SEARCH) && !$past(!rst_n)) |=> $stable(hit_count_r))
    else $error("hit count changed during a search");
`endif

endmodule

/* rtl/stmc_table_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmc_table_ram: single-write, single-read table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stmc_table_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/stmc_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmc_search: binary search sequencer
// Keeps a half-open window [lo, hi), probes its middle one entry per cycle
// and narrows the window with a single shared signed compare.
// ----------------------------------------------------------------------------
module stmc_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stmc_pkg::search_req_t req,
  input  stmc_pkg::value_t     rd_data,
  output logic                 rd_en,
  output stmc_pkg::addr_t      rd_addr,
  output stmc_pkg::search_rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t             state_r, state_nxt;
  stmc_pkg::cnt_t     lo_r, lo_nxt;
  stmc_pkg::cnt_t     hi_r, hi_nxt;
  stmc_pkg::cnt_t     mid_r, mid_nxt;
  stmc_pkg::value_t   key_r, key_nxt;
  logic               done_r, done_nxt;
  logic               hit_r, hit_nxt;
  logic               probe_eq;
  logic               probe_lt;

  // Middle of [lo, hi): lo + (hi - lo - 1) / 2, valid while lo < hi
  function automatic stmc_pkg::cnt_t mid_of(stmc_pkg::cnt_t lo, stmc_pkg::cnt_t hi);
    stmc_pkg::cnt_t span;
    span = hi - lo - stmc_pkg::cnt_t'(1);
    return lo + (span >> 1);
  endfunction

  assign probe_eq = (rd_data == key_r);
  assign probe_lt = ($signed(rd_data) < $signed(key_r));

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    key_nxt   = key_r;
    done_nxt  = 1'b0;
    hit_nxt   = hit_r;
    rd_en     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          lo_nxt  = '0;
          hi_nxt  = req.count;
          key_nxt = req.key;
          if (req.count == '0) begin
            done_nxt = 1'b1;
            hit_nxt  = 1'b0;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (probe_eq) begin
          done_nxt  = 1'b1;
          hit_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (probe_lt) begin
            lo_nxt = mid_r + stmc_pkg::cnt_t'(1);
          end else begin
            hi_nxt = mid_r;
          end
          if (lo_nxt >= hi_nxt) begin
            done_nxt  = 1'b1;
            hit_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    mid_nxt = mid_of(lo_nxt, hi_nxt);
  end

  assign rd_addr = mid_nxt[stmc_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    hit_r <= hit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;

endmodule
